// ----- rtl/e2q_pkg.sv -----
// Shared constants, types and tables for the Euler angle to quaternion core.
`timescale 1ns / 1ps

package e2q_pkg;

    // Iteration count of the rotation and the number actually built.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // Field and datapath widths.
    localparam int AW = 16;   // input angle
    localparam int QW = 16;   // output component
    localparam int XW = 34;   // CORDIC x and y, Q2.30 with headroom
    localparam int ZW = 33;   // CORDIC residual angle, binary angle units
    localparam int TW = 22;   // sine and cosine in Q20
    localparam int PW = 2 * TW;
    localparam int SW = PW + 1;
    localparam int SH_W = 5;

    // Angle conversion: degrees Q7 to half-angle binary units is mag * 2^21 / 45.
    localparam int DIV_45 = 45;
    localparam logic [16:0] RECIP_45 = 17'd93207;   // ceil(2^22 / 45)
    localparam int RECIP_SHIFT = 22;
    localparam int REM_W = 21;
    localparam int HALF_RND = 22;

    typedef logic [DIV_45-1:0][REM_W-1:0] rem_tab_t;

    // Remainder table: floor((r * 2^21 + 22) / 45) for r below 45.
    function automatic rem_tab_t rem_tab_init();
        rem_tab_t t;
        longint v;
        for (int r = 0; r < DIV_45; r++) begin
            v = (longint'(r) << 21) + HALF_RND;
            t[r] = REM_W'(v / DIV_45);
        end
        return t;
    endfunction

    localparam rem_tab_t REM_TAB = rem_tab_init();

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(34'sh026DD3B6A);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(33'sh040000000);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(33'sh080000000);

    localparam logic [31:0] ATAN_BAM [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Pipeline depth: angle prep, one cell per step, then five product stages.
    localparam int LAT = 3 + STEPS + 5;

    localparam logic signed [QW-1:0] SAT_HI = 16'sd32767;
    localparam logic signed [QW-1:0] SAT_LO = -16'sd32767;

    // Round a Q40 sum to Q15 and saturate.
    function automatic logic signed [QW-1:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        logic signed [19:0] q;
        t = s + SW'(1 << 24);
        q = t[SW-1:25];
        if (q > 20'(SAT_HI))
            return SAT_HI;
        else if (q < 20'(SAT_LO))
            return SAT_LO;
        else
            return q[QW-1:0];
    endfunction

endpackage

// ----- rtl/e2q_angle_prep.sv -----
// Converts one angle in degrees to a folded half-angle in binary angle units.
`timescale 1ns / 1ps

module e2q_angle_prep (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [e2q_pkg::AW-1:0]    angle,
    output logic signed [e2q_pkg::ZW-1:0]    z,
    output logic                             flip
);

    logic [16:0]                    mag;
    logic [16:0]                    mag_reg;
    logic [33:0]                    prod_reg;
    logic                           neg1_reg;
    logic [9:0]                     quo;
    logic [16:0]                    rem_full;
    logic [5:0]                     rem;
    logic [30:0]                    zmag_next;
    logic [30:0]                    zmag_reg;
    logic                           neg2_reg;
    logic signed [e2q_pkg::ZW-1:0]  zs;
    logic signed [e2q_pkg::ZW-1:0]  z_next;
    logic                           flip_next;
    logic signed [e2q_pkg::ZW-1:0]  z_reg;
    logic                           flip_reg;

    // Magnitude and reciprocal product for the division by 45.
    assign mag = angle[e2q_pkg::AW-1] ? 17'(-{angle[e2q_pkg::AW-1], angle})
                                      : 17'({1'b0, angle});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag;
            prod_reg <= 34'(mag * e2q_pkg::RECIP_45);
            neg1_reg <= angle[e2q_pkg::AW-1];
        end
    end

    // Quotient, remainder and the scaled half-angle magnitude.
    assign quo = prod_reg[e2q_pkg::RECIP_SHIFT +: 10];
    assign rem_full = mag_reg - 17'(quo * 6'd45);
    assign rem = rem_full[5:0];
    assign zmag_next = {quo, 21'b0} + 31'(e2q_pkg::REM_TAB[rem]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zmag_reg <= zmag_next;
            neg2_reg <= neg1_reg;
        end
    end

    // Reapply the sign and fold into plus or minus 90 degrees.
    assign zs = neg2_reg ? -e2q_pkg::ZW'({2'b0, zmag_reg}) : e2q_pkg::ZW'({2'b0, zmag_reg});

    always_comb
    begin
        z_next = zs;
        flip_next = 1'b0;
        if (zs > e2q_pkg::QUARTER_TURN)
        begin
            z_next = zs - e2q_pkg::HALF_TURN;
            flip_next = 1'b1;
        end
        else if (zs < -e2q_pkg::QUARTER_TURN)
        begin
            z_next = zs + e2q_pkg::HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign z = z_reg;
    assign flip = flip_reg;

endmodule

// ----- rtl/e2q_cordic_cell.sv -----
// One rotation step of the CORDIC chain.
`timescale 1ns / 1ps

module e2q_cordic_cell (
    input  logic                               clk,
    input  logic                               en,
    input  logic [e2q_pkg::SH_W-1:0]           shamt,
    input  logic [31:0]                        atan,
    input  logic signed [e2q_pkg::XW-1:0]      x_in,
    input  logic signed [e2q_pkg::XW-1:0]      y_in,
    input  logic signed [e2q_pkg::ZW-1:0]      z_in,
    input  logic                               flip_in,
    output logic signed [e2q_pkg::XW-1:0]      x_out,
    output logic signed [e2q_pkg::XW-1:0]      y_out,
    output logic signed [e2q_pkg::ZW-1:0]      z_out,
    output logic                               flip_out
);

    logic signed [e2q_pkg::XW-1:0] dx;
    logic signed [e2q_pkg::XW-1:0] dy;
    logic signed [e2q_pkg::ZW-1:0] da;
    logic signed [e2q_pkg::XW-1:0] x_reg;
    logic signed [e2q_pkg::XW-1:0] y_reg;
    logic signed [e2q_pkg::ZW-1:0] z_reg;
    logic                          flip_reg;

    assign dx = y_in >>> shamt;
    assign dy = x_in >>> shamt;
    assign da = e2q_pkg::ZW'({1'b0, atan});

    // Rotate toward a zero residual; a non-negative residual turns positive.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[e2q_pkg::ZW-1])
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - da;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + da;
            end
            flip_reg <= flip_in;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign flip_out = flip_reg;

endmodule

// ----- rtl/e2q_quat_mul.sv -----
// Rounds the sines and cosines and forms the four quaternion components.
`timescale 1ns / 1ps

module e2q_quat_mul (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [e2q_pkg::XW-1:0]     cx [3],
    input  logic signed [e2q_pkg::XW-1:0]     cy [3],
    input  logic                              flip [3],
    output logic signed [e2q_pkg::QW-1:0]     qw,
    output logic signed [e2q_pkg::QW-1:0]     qx,
    output logic signed [e2q_pkg::QW-1:0]     qy,
    output logic signed [e2q_pkg::QW-1:0]     qz
);

    logic signed [e2q_pkg::XW-1:0] rx [3];
    logic signed [e2q_pkg::XW-1:0] ry [3];
    logic signed [e2q_pkg::TW-1:0] c_reg [3];
    logic signed [e2q_pkg::TW-1:0] s_reg [3];
    logic signed [e2q_pkg::PW-1:0] p_reg [4];
    logic signed [e2q_pkg::TW-1:0] cy1_reg, sy1_reg, cy2_reg, sy2_reg;
    logic signed [e2q_pkg::PW-1:0] pr [4];
    logic signed [e2q_pkg::TW-1:0] r_reg [4];
    logic signed [e2q_pkg::PW-1:0] t_reg [8];
    logic signed [e2q_pkg::QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    // Round each cosine and sine to Q20 and undo the fold.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rx[i] = cx[i] + e2q_pkg::XW'(512);
            ry[i] = cy[i] + e2q_pkg::XW'(512);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= flip[i] ? -rx[i][31:10] : rx[i][31:10];
                s_reg[i] <= flip[i] ? -ry[i][31:10] : ry[i][31:10];
            end
        end
    end

    // Roll and pitch products: cr*cp, sr*sp, sr*cp, cr*sp.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= c_reg[0] * c_reg[1];
            p_reg[1] <= s_reg[0] * s_reg[1];
            p_reg[2] <= s_reg[0] * c_reg[1];
            p_reg[3] <= c_reg[0] * s_reg[1];
            cy1_reg  <= c_reg[2];
            sy1_reg  <= s_reg[2];
        end
    end

    // Round the pair products to Q20.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            pr[i] = p_reg[i] + e2q_pkg::PW'(1 << 19);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                r_reg[i] <= pr[i][41:20];
            cy2_reg <= cy1_reg;
            sy2_reg <= sy1_reg;
        end
    end

    // Yaw products in Q40.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= r_reg[0] * cy2_reg;
            t_reg[1] <= r_reg[1] * sy2_reg;
            t_reg[2] <= r_reg[2] * cy2_reg;
            t_reg[3] <= r_reg[3] * sy2_reg;
            t_reg[4] <= r_reg[3] * cy2_reg;
            t_reg[5] <= r_reg[2] * sy2_reg;
            t_reg[6] <= r_reg[0] * sy2_reg;
            t_reg[7] <= r_reg[1] * cy2_reg;
        end
    end

    // Sum the term pairs, round to Q15 and saturate.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qw_reg <= e2q_pkg::round_sat(e2q_pkg::SW'(t_reg[0]) + e2q_pkg::SW'(t_reg[1]));
            qx_reg <= e2q_pkg::round_sat(e2q_pkg::SW'(t_reg[2]) - e2q_pkg::SW'(t_reg[3]));
            qy_reg <= e2q_pkg::round_sat(e2q_pkg::SW'(t_reg[4]) + e2q_pkg::SW'(t_reg[5]));
            qz_reg <= e2q_pkg::round_sat(e2q_pkg::SW'(t_reg[6]) - e2q_pkg::SW'(t_reg[7]));
        end
    end

    assign qw = qw_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;
    assign qz = qz_reg;

endmodule

// ----- rtl/euler_to_quaternion_core.sv -----
// Top level: Euler angles in degrees to a Z-Y-X unit quaternion in Q1.15.
`timescale 1ns / 1ps

// Takes one word of roll, pitch and yaw per cycle unless the pipeline holds,
// and returns one quaternion word per input word, in order. Each angle runs
// through its own chain of CORDIC cells, one cell per rotation step, with
// 16 steps, and a new word can enter every cycle while the pipeline advances.
// The whole pipeline holds when a finished word waits at the output.

module euler_to_quaternion_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [e2q_pkg::AW-1:0]    roll_angle,
    input  logic signed [e2q_pkg::AW-1:0]    pitch_angle,
    input  logic signed [e2q_pkg::AW-1:0]    yaw_angle,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [e2q_pkg::QW-1:0]    quat_w,
    output logic signed [e2q_pkg::QW-1:0]    quat_x,
    output logic signed [e2q_pkg::QW-1:0]    quat_y,
    output logic signed [e2q_pkg::QW-1:0]    quat_z
);

    logic                             en;
    logic [e2q_pkg::LAT-1:0]          vld_reg;
    logic signed [e2q_pkg::AW-1:0]    angles [3];
    logic signed [e2q_pkg::XW-1:0]    xc [3][e2q_pkg::STEPS+1];
    logic signed [e2q_pkg::XW-1:0]    yc [3][e2q_pkg::STEPS+1];
    logic signed [e2q_pkg::ZW-1:0]    zc [3][e2q_pkg::STEPS+1];
    logic                             fc [3][e2q_pkg::STEPS+1];
    logic signed [e2q_pkg::XW-1:0]    x_end [3];
    logic signed [e2q_pkg::XW-1:0]    y_end [3];
    logic                             f_end [3];

    // The pipeline advances unless a finished word is stalled at the output.
    assign en = !vld_reg[e2q_pkg::LAT-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[e2q_pkg::LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[e2q_pkg::LAT-2:0], in_valid};
    end

    assign angles[0] = roll_angle;
    assign angles[1] = pitch_angle;
    assign angles[2] = yaw_angle;

    // One angle lane per input: conversion, then the chain of cells.
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        e2q_angle_prep u_prep (
            .clk   (clk),
            .en    (en),
            .angle (angles[g]),
            .z     (zc[g][0]),
            .flip  (fc[g][0])
        );

        assign xc[g][0] = e2q_pkg::CORDIC_GAIN;
        assign yc[g][0] = '0;

        for (genvar k = 0; k < e2q_pkg::STEPS; k++)
        begin : g_cell
            e2q_cordic_cell u_cell (
                .clk      (clk),
                .en       (en),
                .shamt    (e2q_pkg::SH_W'(k)),
                .atan     (e2q_pkg::ATAN_BAM[k]),
                .x_in     (xc[g][k]),
                .y_in     (yc[g][k]),
                .z_in     (zc[g][k]),
                .flip_in  (fc[g][k]),
                .x_out    (xc[g][k+1]),
                .y_out    (yc[g][k+1]),
                .z_out    (zc[g][k+1]),
                .flip_out (fc[g][k+1])
            );
        end

        assign x_end[g] = xc[g][e2q_pkg::STEPS];
        assign y_end[g] = yc[g][e2q_pkg::STEPS];
        assign f_end[g] = fc[g][e2q_pkg::STEPS];
    end

    // Quaternion products and output registers.
    e2q_quat_mul u_mul (
        .clk  (clk),
        .en   (en),
        .cx   (x_end),
        .cy   (y_end),
        .flip (f_end),
        .qw   (quat_w),
        .qx   (quat_x),
        .qy   (quat_y),
        .qz   (quat_z)
    );

endmodule

// ----- tb/tb_euler_to_quaternion_core.sv -----
// Testbench for the Euler angle to quaternion core: directed and random words checked in order.
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;

    typedef struct packed {
        logic signed [e2q_pkg::AW-1:0] roll;
        logic signed [e2q_pkg::AW-1:0] pitch;
        logic signed [e2q_pkg::AW-1:0] yaw;
    } pose_t;

    typedef struct packed {
        logic signed [e2q_pkg::QW-1:0] w;
        logic signed [e2q_pkg::QW-1:0] x;
        logic signed [e2q_pkg::QW-1:0] y;
        logic signed [e2q_pkg::QW-1:0] z;
    } quat_t;

    localparam int RANDOM_WORDS = 950;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [e2q_pkg::AW-1:0] roll_angle = '0;
    logic signed [e2q_pkg::AW-1:0] pitch_angle = '0;
    logic signed [e2q_pkg::AW-1:0] yaw_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [e2q_pkg::QW-1:0] quat_w, quat_x, quat_y, quat_z;

    pose_t pending_poses[$];
    quat_t expected_quats[$];
    int mismatches = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 82;
    int hold_cycles = 0;
    bit hold_done = 1'b0;
    bit in_accepted = 1'b0;

    euler_to_quaternion_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    always #4 clk = ~clk;

    // Floor shift of a signed value.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Cosine and sine of half the angle in Q20, by rotation.
    function automatic void half_trig(input logic signed [e2q_pkg::AW-1:0] deg,
                                      output longint c, output longint s);
        longint mag, zr, xr, yr, dx, dy;
        bit flip;
        mag = (deg < 0) ? -longint'(deg) : longint'(deg);
        zr = ((mag <<< 31) + 23040) / 46080;
        flip = 1'b0;
        xr = 64'h26DD3B6A;
        yr = 0;
        if (deg < 0)
            zr = -zr;
        if (zr > 64'sd1073741824)
        begin
            zr -= 64'sd2147483648;
            flip = 1'b1;
        end
        else if (zr < -64'sd1073741824)
        begin
            zr += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < e2q_pkg::STEPS; i++)
        begin
            dx = floor_shift(yr, i);
            dy = floor_shift(xr, i);
            if (zr >= 0)
            begin
                xr -= dx;
                yr += dy;
                zr -= longint'(e2q_pkg::ATAN_BAM[i]);
            end
            else
            begin
                xr += dx;
                yr -= dy;
                zr += longint'(e2q_pkg::ATAN_BAM[i]);
            end
        end
        xr = round_shift(xr, 10);
        yr = round_shift(yr, 10);
        c = flip ? -xr : xr;
        s = flip ? -yr : yr;
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return round_shift(a * b, 20) * c;
    endfunction

    function automatic logic signed [e2q_pkg::QW-1:0] to_q15(longint sum);
        longint q;
        q = round_shift(sum, 25);
        if (q > 32767)
            q = 32767;
        if (q < -32767)
            q = -32767;
        return e2q_pkg::QW'(q);
    endfunction

    // Z-Y-X quaternion of one pose.
    function automatic quat_t pose_to_quat(pose_t p);
        longint cr, sr, cp, sp, cy, sy;
        quat_t q;
        half_trig(p.roll, cr, sr);
        half_trig(p.pitch, cp, sp);
        half_trig(p.yaw, cy, sy);
        q.w = to_q15(triple(cr, cp, cy) + triple(sr, sp, sy));
        q.x = to_q15(triple(sr, cp, cy) - triple(cr, sp, sy));
        q.y = to_q15(triple(cr, sp, cy) + triple(sr, cp, sy));
        q.z = to_q15(triple(cr, cp, sy) - triple(sr, sp, cy));
        return q;
    endfunction

    function automatic logic signed [e2q_pkg::AW-1:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return e2q_pkg::AW'($urandom);
        else if (pick == 1)
            return (($urandom_range(0, 1) != 0) ? 16'sd23040 : -16'sd23040);
        return e2q_pkg::AW'($urandom_range(0, 46080) - 23040);
    endfunction

    function automatic pose_t mk(int r, int p, int y);
        pose_t t;
        t.roll = e2q_pkg::AW'(r);
        t.pitch = e2q_pkg::AW'(p);
        t.yaw = e2q_pkg::AW'(y);
        return t;
    endfunction

    // Append one pose to the pending queue.
    function automatic void add_pose(pose_t p);
        pending_poses.insert(pending_poses.size(), p);
    endfunction

    // Fill the queue of poses: directed corners first, then random ones.
    initial
    begin
        add_pose(mk(0, 0, 0));
        add_pose(mk(23040, 0, 0));
        add_pose(mk(-23040, 0, 0));
        add_pose(mk(0, 23040, 0));
        add_pose(mk(0, -23040, 0));
        add_pose(mk(0, 0, 23040));
        add_pose(mk(0, 0, -23040));
        add_pose(mk(23040, 23040, 23040));
        add_pose(mk(-23040, -23040, -23040));
        add_pose(mk(32767, -32768, 32767));
        add_pose(mk(-32768, 32767, -32768));
        add_pose(mk(23041, -23041, 30000));
        add_pose(mk(11520, -11520, 11520));
        add_pose(mk(1, -1, 1));
        add_pose(mk(-1, 1, -1));
        add_pose(mk(16'h5555, 16'hAAAA, 16'h7FFF));
        add_pose(mk(16'hAAAA, 16'h5555, 16'h8000));
        for (int i = 0; i < RANDOM_WORDS; i++)
            add_pose(mk(rand_angle(), rand_angle(), rand_angle()));
    end

    // Reset, idle schedule and the end of the run.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pending_poses.size() < 500);
        send_idle_pct = 82;
        recv_idle_pct = 7;
        wait (pending_poses.size() < 250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_poses.size() == 0 && !in_valid);
        wait (expected_quats.size() == 0);
        repeat (e2q_pkg::LAT + 10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Sender: offer a new word at the falling edge, keeping it until taken.
    always @(negedge clk)
    begin
        pose_t p;
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (pending_poses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                p = pending_poses.pop_front();
                roll_angle <= p.roll;
                pitch_angle <= p.pitch;
                yaw_angle <= p.yaw;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random ready, or held low once for a counted stretch.
    always @(negedge clk)
    begin
        if (rst_n && !hold_done && pending_poses.size() < 650)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Accepted words are flagged at the rising edge for the sender and their predictions queued.
    always @(posedge clk)
    begin
        in_accepted <= in_valid && in_ready;
        if (in_valid && in_ready)
            expected_quats.insert(expected_quats.size(),
                                  pose_to_quat('{roll_angle, pitch_angle, yaw_angle}));
    end

    // Monitor: compare each quaternion word with the oldest prediction.
    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word w=%0d x=%0d y=%0d z=%0d",
                             quat_w, quat_x, quat_y, quat_z);
            end
            else
            begin
                e = expected_quats.pop_front();
                if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                                 e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
                end
            end
        end
    end

endmodule

// ----- euler_to_quaternion_core.f -----
rtl/e2q_pkg.sv
rtl/e2q_angle_prep.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_quat_mul.sv
rtl/euler_to_quaternion_core.sv
tb/tb_euler_to_quaternion_core.sv
